>>> hw/rtl/cbhs_pkg.sv
`timescale 1ns / 1ps

package cbhs_pkg;

  localparam int unsigned DelayW    = 16;
  localparam int unsigned LimitW    = 4;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned EventW    = 3;
  localparam int unsigned LedW      = 2;
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = DelayW;

  localparam logic [DelayW-1:0] FirstDelayRst   = DelayW'(30);
  localparam logic [DelayW-1:0] PollDelayRst    = DelayW'(10);
  localparam logic [DelayW-1:0] InitDelayRst    = DelayW'(150);
  localparam logic [DelayW-1:0] StartDelayRst   = DelayW'(900);
  localparam logic [DelayW-1:0] RestartDelayRst = DelayW'(5);
  localparam logic [LimitW-1:0] FailLimitRst    = LimitW'(3);
  localparam logic [LimitW-1:0] ErrRunMax       = '1;

  // progress byte codes
  localparam logic [ByteW-1:0] ProgCpOk   = ByteW'(1);
  localparam logic [ByteW-1:0] ProgDpOk   = ByteW'(2);
  localparam logic [ByteW-1:0] ProgCpuOk  = ByteW'(3);
  localparam logic [ByteW-1:0] ProgReboot = ByteW'(4);

  typedef enum logic [EventW-1:0] {
    EV_NONE    = 3'd0,
    EV_PATH    = 3'd1,
    EV_INIT    = 3'd2,
    EV_START   = 3'd3,
    EV_LED     = 3'd4,
    EV_FAULT   = 3'd5,
    EV_REBOOT  = 3'd6,
    EV_UNKNOWN = 3'd7
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FIRST_DELAY   = 3'd0,
    REG_POLL_DELAY    = 3'd1,
    REG_INIT_DELAY    = 3'd2,
    REG_START_DELAY   = 3'd3,
    REG_RESTART_DELAY = 3'd4,
    REG_FAIL_LIMIT    = 3'd5
  } reg_idx_e;

  typedef enum logic [LedW-1:0] {
    COLOR_RED    = 2'd0,
    COLOR_YELLOW = 2'd1,
    COLOR_BLUE   = 2'd2
  } led_color_e;

  typedef enum logic [LedW-1:0] {
    LED_SLOW   = 2'd0,
    LED_FAST   = 2'd1,
    LED_STEADY = 2'd2
  } led_speed_e;

  typedef enum logic [3:0] {
    PH_FIRST = 4'b0001,
    PH_INIT  = 4'b0010,
    PH_START = 4'b0100,
    PH_CHECK = 4'b1000
  } phase_e;

  localparam logic [PhaseW-1:0] PhCodeFirst = 2'd0;
  localparam logic [PhaseW-1:0] PhCodeInit  = 2'd1;
  localparam logic [PhaseW-1:0] PhCodeStart = 2'd2;
  localparam logic [PhaseW-1:0] PhCodeCheck = 2'd3;

  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] code;
    case (ph)
      PH_FIRST: code = PhCodeFirst;
      PH_INIT:  code = PhCodeInit;
      PH_START: code = PhCodeStart;
      PH_CHECK: code = PhCodeCheck;
      default:  code = PhCodeFirst;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/cbhs_if.sv
`timescale 1ns / 1ps

interface cbhs_in_if import cbhs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] cpu_error_code;
  logic [ByteW-1:0] boot_progress;

  modport source (output valid, output cpu_error_code, output boot_progress, input ready);
  modport sink   (input valid, input cpu_error_code, input boot_progress, output ready);
endinterface

interface cbhs_out_if import cbhs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_code;
  logic              run_script;
  logic              led_write;
  logic [LedW-1:0]   led_color;
  logic [LedW-1:0]   led_speed;
  logic              led_to_bmc;
  logic [PhaseW-1:0] phase_now;
  logic [LimitW-1:0] fault_count;

  modport source (output valid, output event_code, output run_script, output led_write,
                  output led_color, output led_speed, output led_to_bmc,
                  output phase_now, output fault_count, input ready);
  modport sink   (input valid, input event_code, input run_script, input led_write,
                  input led_color, input led_speed, input led_to_bmc,
                  input phase_now, input fault_count, output ready);
endinterface

>>> hw/rtl/cpu_boot_health_supervisor.sv
`timescale 1ns / 1ps

// Boot and health supervisor for a CPU, stepped once per 100 ms tick beat.
// Every input beat gives exactly one result beat, in the cycle after it is taken;
// a new tick is accepted every cycle as long as the result register is empty
// or being drained in the same cycle, so throughput is one tick per clock and
// is set only by the single result register. The phase countdown, the error
// run counter and the last progress byte are updated in the accepting cycle.
// Delay registers are in ticks; a delay of zero behaves as one. Writing
// first_delay while still in the first phase also reloads the countdown.
// Configure only while no tick is in flight.
module cpu_boot_health_supervisor import cbhs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  cbhs_in_if.sink             in_i,
  cbhs_out_if.source          out_o
);

  // configuration
  logic [DelayW-1:0] poll_delay_q, init_delay_q;
  logic [DelayW-1:0] start_delay_q, restart_delay_q;
  logic [LimitW-1:0] fail_limit_q;

  // supervisor state
  phase_e            phase_q, phase_d;
  logic [DelayW-1:0] countdown_q, countdown_d;
  logic [LimitW-1:0] err_run_q, err_run_d;
  logic [ByteW-1:0]  last_prog_q, last_prog_d;
  logic              last_valid_q, last_valid_d;

  // result register
  logic              out_valid_q;
  event_e            ev_q, ev_d;
  logic              run_q, run_d;
  logic              lw_q, lw_d;
  logic [LedW-1:0]   color_q, color_d;
  logic [LedW-1:0]   speed_q, speed_d;
  logic              bmc_q, bmc_d;

  logic              in_fire;
  logic [LimitW-1:0] err_next;
  logic              prog_changed;
  logic              first_reload;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // first_delay only matters before the first check: it just reloads the countdown
  assign first_reload = cfg_we_i && (cfg_idx_i == REG_FIRST_DELAY) && (phase_q == PH_FIRST);

  always_comb begin
    if (in_i.cpu_error_code != '0) begin
      err_next = (err_run_q == ErrRunMax) ? err_run_q : err_run_q + LimitW'(1);
    end else begin
      err_next = '0;
    end
    prog_changed = !last_valid_q || (in_i.boot_progress != last_prog_q);
  end

  always_comb begin
    phase_d      = phase_q;
    countdown_d  = countdown_q;
    err_run_d    = err_run_q;
    last_prog_d  = last_prog_q;
    last_valid_d = last_valid_q;
    ev_d         = EV_NONE;
    run_d        = 1'b0;
    lw_d         = 1'b0;
    color_d      = COLOR_RED;
    speed_d      = LED_SLOW;
    bmc_d        = 1'b0;

    if (countdown_q > DelayW'(1)) begin
      countdown_d = countdown_q - DelayW'(1);
    end else begin
      case (phase_q)
        PH_FIRST: begin
          ev_d        = EV_PATH;
          bmc_d       = 1'b1;
          lw_d        = 1'b1;
          phase_d     = (in_i.boot_progress == ProgDpOk) ? PH_CHECK : PH_INIT;
          countdown_d = poll_delay_q;
        end
        PH_INIT: begin
          ev_d        = EV_INIT;
          run_d       = 1'b1;
          phase_d     = PH_START;
          countdown_d = init_delay_q;
        end
        PH_START: begin
          ev_d        = EV_START;
          run_d       = 1'b1;
          bmc_d       = 1'b1;
          lw_d        = 1'b1;
          color_d     = COLOR_YELLOW;
          speed_d     = LED_FAST;
          phase_d     = PH_CHECK;
          countdown_d = start_delay_q;
        end
        default: begin
          err_run_d   = err_next;
          phase_d     = PH_CHECK;
          countdown_d = poll_delay_q;
          if (err_next >= fail_limit_q) begin
            // fault restart wins; progress byte is not looked at
            ev_d        = EV_FAULT;
            err_run_d   = '0;
            phase_d     = PH_START;
            countdown_d = restart_delay_q;
          end else if (prog_changed) begin
            last_prog_d  = in_i.boot_progress;
            last_valid_d = 1'b1;
            case (in_i.boot_progress)
              ProgCpOk: begin
                ev_d    = EV_LED;
                lw_d    = 1'b1;
                color_d = COLOR_BLUE;
                speed_d = LED_SLOW;
              end
              ProgDpOk: begin
                ev_d    = EV_LED;
                lw_d    = 1'b1;
                color_d = COLOR_BLUE;
                speed_d = LED_STEADY;
              end
              ProgCpuOk: begin
                ev_d    = EV_LED;
                lw_d    = 1'b1;
                color_d = COLOR_YELLOW;
                speed_d = LED_SLOW;
              end
              ProgReboot: begin
                ev_d        = EV_REBOOT;
                phase_d     = PH_START;
                countdown_d = restart_delay_q;
              end
              default: ev_d = EV_UNKNOWN;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_delay_q    <= PollDelayRst;
      init_delay_q    <= InitDelayRst;
      start_delay_q   <= StartDelayRst;
      restart_delay_q <= RestartDelayRst;
      fail_limit_q    <= FailLimitRst;
      phase_q         <= PH_FIRST;
      countdown_q     <= FirstDelayRst;
      err_run_q       <= '0;
      last_prog_q     <= '0;
      last_valid_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q      <= phase_d;
        err_run_q    <= err_run_d;
        last_prog_q  <= last_prog_d;
        last_valid_q <= last_valid_d;
      end
      if (first_reload) begin
        countdown_q <= cfg_wdata_i;
      end else if (in_fire) begin
        countdown_q <= countdown_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POLL_DELAY:    poll_delay_q    <= cfg_wdata_i;
          REG_INIT_DELAY:    init_delay_q    <= cfg_wdata_i;
          REG_START_DELAY:   start_delay_q   <= cfg_wdata_i;
          REG_RESTART_DELAY: restart_delay_q <= cfg_wdata_i;
          REG_FAIL_LIMIT:    fail_limit_q    <= cfg_wdata_i[LimitW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload: load on every accepted tick, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q    <= ev_d;
      run_q   <= run_d;
      lw_q    <= lw_d;
      color_q <= color_d;
      speed_q <= speed_d;
      bmc_q   <= bmc_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.event_code  = ev_q;
  assign out_o.run_script  = run_q;
  assign out_o.led_write   = lw_q;
  assign out_o.led_color   = color_q;
  assign out_o.led_speed   = speed_q;
  assign out_o.led_to_bmc  = bmc_q;
  assign out_o.phase_now   = phase_code(phase_q);
  assign out_o.fault_count = err_run_q;

  // a taken tick always shows up as a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_o.valid)
    else $error("accepted tick produced no result");

  // a fault restart leaves the error run cleared and the phase at start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.event_code == EV_FAULT) |->
      (out_o.fault_count == '0 && out_o.phase_now == PhCodeStart))
    else $error("fault restart did not clear error run");

  // script runs only come from the init and start actions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.run_script) |->
      (out_o.event_code == EV_INIT || out_o.event_code == EV_START))
    else $error("run_script outside init or start action");

  // without a LED write the color and speed fields stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.led_write) |->
      (out_o.led_color == COLOR_RED && out_o.led_speed == LED_SLOW))
    else $error("LED fields set without led_write");

endmodule
